FILE: rtl/ialu_pkg.sv
// Package: operation codes, widths and pipeline payload types for the integer ALU.
package ialu_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned CMD_W = 4;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES = XLEN / DIV_BITS_PER_STAGE;
  localparam int unsigned PIPE_DEPTH = DIV_STAGES + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_MUL  = 4'd2,
    CMD_DIV  = 4'd3,
    CMD_REM  = 4'd4,
    CMD_LT   = 4'd5,
    CMD_GT   = 4'd6,
    CMD_LE   = 4'd7,
    CMD_GE   = 4'd8,
    CMD_EQ   = 4'd9,
    CMD_NE   = 4'd10,
    CMD_PLUS = 4'd11,
    CMD_NEG  = 4'd12,
    CMD_NOT  = 4'd13
  } cmd_e;

  // Word carried down the divide pipeline.
  typedef struct packed {
    logic            is_rem;   // deliver remainder instead of quotient
    logic            neg_res;  // negate the final magnitude
    logic            div_op;   // word is a div or rem that needs the array
    logic [XLEN-1:0] fast;     // result of any non-divide operation
    logic            dz;       // divide by zero
    logic [XLEN-1:0] quo;      // quotient bits, dividend shifts out
    logic [XLEN-1:0] rem;      // partial remainder
    logic [XLEN-1:0] dsr;      // divisor magnitude
  } pipe_t;

endpackage

FILE: rtl/ialu_stream_if.sv
// Interface: valid/ready stream channel with an ALU operation or result payload.
interface ialu_stream_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ialu_front.sv
// Front stage: decode, fast operations, low-word multiply and divide setup.
module ialu_front
  import ialu_pkg::*;
(
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [XLEN-1:0]  operand_a_i,
  input  logic [XLEN-1:0]  operand_b_i,
  output pipe_t            word_o
);
  logic            na, nb, bzero;
  logic [XLEN-1:0] ma, mb, sum, dif, prod;
  logic            slt, sgt;

  always_comb begin
    na    = operand_a_i[XLEN-1];
    nb    = operand_b_i[XLEN-1];
    ma    = na ? (~operand_a_i + 1'b1) : operand_a_i;
    mb    = nb ? (~operand_b_i + 1'b1) : operand_b_i;
    bzero = (operand_b_i == '0);
    sum   = operand_a_i + operand_b_i;
    dif   = operand_a_i - operand_b_i;
    prod  = operand_a_i * operand_b_i;
    slt   = $signed(operand_a_i) < $signed(operand_b_i);
    sgt   = $signed(operand_b_i) < $signed(operand_a_i);

    word_o        = '0;
    word_o.is_rem = (cmd_i == CMD_REM);
    word_o.dsr    = mb;
    word_o.quo    = ma;
    case (cmd_i)
      CMD_ADD:  word_o.fast = sum;
      CMD_SUB:  word_o.fast = dif;
      CMD_MUL:  word_o.fast = prod;
      CMD_DIV, CMD_REM: begin
        word_o.dz      = bzero;
        word_o.div_op  = !bzero;
        word_o.neg_res = (cmd_i == CMD_REM) ? na : (na ^ nb);
      end
      CMD_LT:   word_o.fast = {{(XLEN-1){1'b0}}, slt};
      CMD_GT:   word_o.fast = {{(XLEN-1){1'b0}}, sgt};
      CMD_LE:   word_o.fast = {{(XLEN-1){1'b0}}, !sgt};
      CMD_GE:   word_o.fast = {{(XLEN-1){1'b0}}, !slt};
      CMD_EQ:   word_o.fast = {{(XLEN-1){1'b0}}, operand_a_i == operand_b_i};
      CMD_NE:   word_o.fast = {{(XLEN-1){1'b0}}, operand_a_i != operand_b_i};
      CMD_PLUS: word_o.fast = operand_a_i;
      CMD_NEG:  word_o.fast = ~operand_a_i + 1'b1;
      CMD_NOT:  word_o.fast = {{(XLEN-1){1'b0}}, operand_a_i == '0};
      default:  word_o.fast = '0;
    endcase
  end
endmodule

FILE: rtl/ialu_div_step.sv
// Divide stage: a few restoring shift-subtract steps on one pipeline word.
module ialu_div_step
  import ialu_pkg::*;
(
  input  pipe_t word_i,
  output pipe_t word_o
);
  logic [XLEN:0]   trial;
  logic [XLEN-1:0] r, q;

  always_comb begin
    word_o = word_i;
    r      = word_i.rem;
    q      = word_i.quo;
    trial  = '0;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      // Shift the next dividend bit into the partial remainder, try the divisor.
      trial = {r, q[XLEN-1]} - {1'b0, word_i.dsr};
      r     = trial[XLEN] ? {r[XLEN-2:0], q[XLEN-1]} : trial[XLEN-1:0];
      q     = {q[XLEN-2:0], !trial[XLEN]};
    end
    word_o.rem = r;
    word_o.quo = q;
  end
endmodule

FILE: rtl/int32_alu_riscv_div_rules_core.sv
// Top level: pipelined integer ALU with stream channels; x/0 gives zero.
//
// Usage
//   in_if  (sink):   data = {cmd[3:0], operand_a[31:0], operand_b[31:0]}.
//   out_if (source): data = {result_value[31:0], div_by_zero}.
//   A word is moved when valid and ready are both high at a rising clk_i.
// Throughput: one operation per cycle, divide included, unless out_if stalls.
// Depth: PIPE_DEPTH = 10 register stages; an accepted word passes the front
//   register, each divider stage and the output register in order. The depth
//   is set by the divider, eight stages of four quotient bits each, with one
//   front stage (decode, add, compare, low-word multiply) and one output
//   stage (sign fix-up). Every operation takes the same path, so results
//   leave in acceptance order.
// Stall: when out_if.ready is low, the output register holds its word; words
//   behind it still advance into empty stages, so bubbles close up. in_if.ready
//   drops only when every stage holds a word and the receiver stalls.
// Reset: rst_ni (asynchronous, active low) clears all valid bits; payload
//   registers are not reset.
module int32_alu_riscv_div_rules_core
  import ialu_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  ialu_stream_if.sink    in_if,
  ialu_stream_if.source  out_if
);
  // Stage 0 is the front register, stages 1..DIV_STAGES the divider,
  // last the output register.
  pipe_t                word_q [PIPE_DEPTH-1];
  pipe_t                stage_in [PIPE_DEPTH-1];
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] adv;
  pipe_t                front_w;
  logic [XLEN-1:0]      res_q, res_d, mag;
  pipe_t                last_w;

  ialu_front u_front (
    .cmd_i       (in_if.data[2*XLEN+CMD_W-1:2*XLEN]),
    .operand_a_i (in_if.data[2*XLEN-1:XLEN]),
    .operand_b_i (in_if.data[XLEN-1:0]),
    .word_o      (front_w)
  );

  assign stage_in[0] = front_w;
  for (genvar s = 1; s < PIPE_DEPTH-1; s++) begin : g_div
    ialu_div_step u_step (.word_i(word_q[s-1]), .word_o(stage_in[s]));
  end

  // Stage k advances when it is empty or the stage downstream advances.
  always_comb begin
    adv[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || out_if.ready;
    for (int k = PIPE_DEPTH-2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_if.ready = adv[0];

  // From the last divider stage: sign-fixed divide result, fast result or zero.
  always_comb begin
    last_w = word_q[PIPE_DEPTH-2];
    mag    = last_w.is_rem ? last_w.rem : last_w.quo;
    if (last_w.dz) begin
      res_d = '0;
    end else if (last_w.div_op) begin
      res_d = last_w.neg_res ? (~mag + 1'b1) : mag;
    end else begin
      res_d = last_w.fast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_if.valid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  logic dz_q;
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < PIPE_DEPTH-1; k++) begin
      if (adv[k]) word_q[k] <= stage_in[k];
    end
    if (adv[PIPE_DEPTH-1]) begin
      res_q <= res_d;
      dz_q  <= last_w.dz;
    end
  end

  assign out_if.valid = vld_q[PIPE_DEPTH-1];
  assign out_if.data  = {res_q, dz_q};
endmodule

FILE: rtl/ialu_checker.sv
// Checker: port-level properties of the integer ALU, bound to the top level.
module ialu_checker
  import ialu_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic [2*XLEN+CMD_W-1:0]  in_data_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [XLEN:0]            out_data_i
);
  a_dz_clears_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i[0] |-> out_data_i[XLEN:1] == '0)
    else $error("divide by zero with nonzero value");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_data_i))
    else $error("unknown input word");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid after reset");
endmodule

bind int32_alu_riscv_div_rules_core ialu_checker u_ialu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .in_data_i   (in_if.data),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
